// ===== rtl/q5k_pkg.sv =====
// q5k_pkg: types, constants and the fp16 decode function for the Q5_K block dequantizer.
// Has no dependencies. Used by q5k_store and q5k_block_dequantizer_core.
package q5k_pkg;

  localparam int unsigned WORD_COUNT = 22;
  localparam logic [4:0] HI_WORD_BASE = 5'd2;
  localparam logic [4:0] LO_WORD_BASE = 5'd6;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [63:0] data;
  } wr_t;

  typedef struct packed {
    logic              sign;
    logic              inf;
    logic              nan;
    logic [10:0]       mag;
    logic signed [5:0] expo;
  } half_t;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_W0   = 12'b0000_0000_0010,
    S_W1   = 12'b0000_0000_0100,
    S_WH   = 12'b0000_0000_1000,
    S_WL   = 12'b0000_0001_0000,
    S_M1   = 12'b0000_0010_0000,
    S_M2   = 12'b0000_0100_0000,
    S_M3   = 12'b0000_1000_0000,
    S_ALN  = 12'b0001_0000_0000,
    S_NRM  = 12'b0010_0000_0000,
    S_RND  = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  // value = mag * 2^expo for finite inputs
  function automatic half_t half_dec(input logic [15:0] h);
    half_t r;
    r.sign = h[15];
    r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    if (h[14:10] == 5'd0) begin
      r.mag  = {1'b0, h[9:0]};
      r.expo = -6'sd24;
    end else begin
      r.mag  = {1'b1, h[9:0]};
      r.expo = $signed(6'({1'b0, h[14:10]}) - 6'd25);
    end
    return r;
  endfunction

endpackage

// ===== rtl/q5k_store.sv =====
// q5k_store: 22 x 64-bit block word memory, one write port and one registered read port.
// Depends on q5k_pkg (wr_t).
module q5k_store (
  input  logic          clk,
  input  q5k_pkg::wr_t  wr,
  input  logic [4:0]    rd_addr,
  output logic [63:0]   rd_data
);
  import q5k_pkg::*;

  logic [63:0] mem [WORD_COUNT];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/q5k_block_dequantizer_core.sv =====
// q5k_block_dequantizer_core: Q5_K block store and element dequantizer, float32 result.
// Depends on q5k_pkg and q5k_store.
//
//   channel | direction | ports
//   in      | input     | in_valid/in_ready, in_kind, in_word_index, in_word_data, in_element_index
//   out     | output    | out_valid/out_ready, out_value_bits
//
// A write gives no item, and the core stays ready. A read holds in_ready low until done;
// normalize shifts by 8 or by 1 bits, 0..12 shifts. NaN, infinite and zero results skip
// normalize and round. Steps: four memory reads, three passes through one shared 11x11
// multiplier, align, normalize, round. Reset is synchronous, active low, and clears
// control only.
// A finished result waits in the output register; a new item may be accepted
// meanwhile, and a read holds in its last step until the output is free.
module q5k_block_dequantizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [4:0]  in_word_index,
  input  logic [63:0] in_word_data,
  input  logic [7:0]  in_element_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value_bits
);
  import q5k_pkg::*;

  state_t state_r, state_nxt;
  logic [7:0]  elem_r;
  logic [63:0] w0_r, w1_r;
  logic        qhi_r;
  logic [4:0]  q_r;
  logic [21:0] scq_r, a_r, b_r;
  logic [51:0] n_r, n_nxt;
  logic [7:0]  e_r, e_nxt;
  logic        sign_r, sign_nxt;
  logic [31:0] res_r, res_nxt;
  logic        out_valid_r;
  logic [31:0] out_bits_r;

  wr_t         wr;
  logic [4:0]  rd_addr;
  logic [63:0] rd_data;

  logic [2:0]  grp;
  logic [4:0]  lane;
  logic [7:0]  sbyte [12];
  logic [5:0]  sc, mn;
  half_t       hd, hm;
  logic [10:0] mul_a, mul_b;
  logic [21:0] prod;
  logic        accept, out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign grp  = elem_r[7:5];
  assign lane = elem_r[4:0];

  assign wr.en   = accept && (in_kind == KIND_WRITE) && (in_word_index < 5'(WORD_COUNT));
  assign wr.addr = in_word_index;
  assign wr.data = in_word_data;

  q5k_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    case (state_r)
      S_W0:    rd_addr = 5'd1;
      S_W1:    rd_addr = HI_WORD_BASE + {3'd0, lane[4:3]};
      S_WH:    rd_addr = LO_WORD_BASE + {1'b0, grp[2:1], lane[4:3]};
      default: rd_addr = 5'd0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sbyte[i] = w0_r[8*(i+4) +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      sbyte[i+4] = w1_r[8*i +: 8];
    end
    if (!grp[2]) begin
      sc = sbyte[4'(grp)][5:0];
      mn = sbyte[4'(grp) + 4'd4][5:0];
    end else begin
      sc = {sbyte[4'(grp) - 4'd4][7:6], sbyte[4'(grp) + 4'd4][3:0]};
      mn = {sbyte[4'(grp)][7:6], sbyte[4'(grp) + 4'd4][7:4]};
    end
  end

  assign hd = half_dec(w0_r[15:0]);
  assign hm = half_dec(w0_r[31:16]);

  always_comb begin
    case (state_r)
      S_M2: begin
        mul_a = hd.mag;
        mul_b = scq_r[10:0];
      end
      S_M3: begin
        mul_a = hm.mag;
        mul_b = {5'd0, mn};
      end
      default: begin
        mul_a = {5'd0, sc};
        mul_b = {6'd0, q_r};
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    logic [4:0]         sh;
    logic [51:0]        a_al, b_al;
    logic signed [5:0]  emin;
    logic signed [53:0] va, vb, diff;
    logic               ainf, anan, binf, bnan, inc;
    state_nxt = state_r;
    n_nxt     = n_r;
    e_nxt     = e_r;
    sign_nxt  = sign_r;
    res_nxt   = res_r;
    sh   = 5'd0;
    a_al = 52'd0;
    b_al = 52'd0;
    emin = hm.expo;
    va   = 54'sd0;
    vb   = 54'sd0;
    diff = 54'sd0;
    ainf = hd.inf && (scq_r != 22'd0);
    anan = hd.nan || (hd.inf && (scq_r == 22'd0));
    binf = hm.inf && (mn != 6'd0);
    bnan = hm.nan || (hm.inf && (mn == 6'd0));
    inc  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_READ)) begin
          state_nxt = S_W0;
        end
      end
      S_W0: state_nxt = S_W1;
      S_W1: state_nxt = S_WH;
      S_WH: state_nxt = S_WL;
      S_WL: state_nxt = S_M1;
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_M3;
      S_M3: state_nxt = S_ALN;
      S_ALN: begin
        if ($signed(hd.expo) >= $signed(hm.expo)) begin
          sh   = 5'($signed(hd.expo) - $signed(hm.expo));
          a_al = {30'd0, a_r} << sh;
          b_al = {30'd0, b_r};
          emin = hm.expo;
        end else begin
          sh   = 5'($signed(hm.expo) - $signed(hd.expo));
          a_al = {30'd0, a_r};
          b_al = {30'd0, b_r} << sh;
          emin = hd.expo;
        end
        va   = hd.sign ? -$signed({2'b00, a_al}) : $signed({2'b00, a_al});
        vb   = hm.sign ? -$signed({2'b00, b_al}) : $signed({2'b00, b_al});
        diff = va - vb;
        sign_nxt = diff[53];
        n_nxt = diff[53] ? 52'(-diff) : diff[51:0];
        e_nxt = 8'({{2{emin[5]}}, emin}) + 8'd51;
        if (anan || bnan || (ainf && binf && (hd.sign == hm.sign))) begin
          res_nxt   = CANON_NAN;
          state_nxt = S_DONE;
        end else if (ainf) begin
          res_nxt   = POS_INF | {hd.sign, 31'd0};
          state_nxt = S_DONE;
        end else if (binf) begin
          res_nxt   = POS_INF | {!hm.sign, 31'd0};
          state_nxt = S_DONE;
        end else if (diff == 54'sd0) begin
          res_nxt = {(a_r == 22'd0) && hd.sign && (b_r == 22'd0) && !hm.sign, 31'd0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NRM;
        end
      end
      S_NRM: begin
        if (n_r[51]) begin
          state_nxt = S_RND;
        end else if (n_r[51:44] == 8'd0) begin
          n_nxt = n_r << 8;
          e_nxt = e_r - 8'd8;
        end else begin
          n_nxt = n_r << 1;
          e_nxt = e_r - 8'd1;
        end
      end
      S_RND: begin
        inc = n_r[27] && ((|n_r[26:0]) || n_r[28]);
        res_nxt = {sign_r, e_r + 8'd127, n_r[50:28]} + {31'd0, inc};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elem_r <= in_element_index;
    end
    case (state_r)
      S_W0: w0_r <= rd_data;
      S_W1: w1_r <= rd_data;
      S_WH: qhi_r <= rd_data[{lane[2:0], 3'd0} + 6'(grp)];
      S_WL: q_r <= {qhi_r, grp[0] ? rd_data[{lane[2:0], 3'd4} +: 4]
                                  : rd_data[{lane[2:0], 3'd0} +: 4]};
      S_M1: scq_r <= prod;
      S_M2: a_r <= prod;
      S_M3: b_r <= prod;
      default: ;
    endcase
    n_r    <= n_nxt;
    e_r    <= e_nxt;
    sign_r <= sign_nxt;
    res_r  <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_bits_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_bits = out_bits_r;

endmodule

// ===== rtl/q5k_block_dequantizer_core_chk.sv =====
// q5k_block_dequantizer_core_chk: port-level checks on the dequantizer core, bound to it.
// Depends on q5k_block_dequantizer_core port names only.
module q5k_block_dequantizer_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out item dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value_bits)) else $error("out item changed");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !in_ready) else $error("ready during read");

  a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind |=> in_ready) else $error("write not single cycle");

endmodule

bind q5k_block_dequantizer_core q5k_block_dequantizer_core_chk u_chk (.*);
